// File: hdl/emp_pkg.sv
package emp_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2
    } mode_t;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

    localparam logic [1:0] TARGET_UP   = 2'd1;
    localparam logic [1:0] TARGET_DOWN = 2'd2;

    localparam logic [1:0] CFG_DRIVE_PCT           = 2'd0;
    localparam logic [1:0] CFG_STOP_LIMIT          = 2'd1;
    localparam logic [1:0] CFG_POLL_PERIOD         = 2'd2;
    localparam logic [1:0] CFG_SWITCHES_ACTIVE_LOW = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVEL_W     = 10;
    localparam int ELAPSED_W   = 17;
    localparam int POLL_W      = 10;

    localparam logic [7:0]           RST_DRIVE_PCT           = 8'd100;
    localparam logic [15:0]          RST_STOP_LIMIT          = 16'd5000;
    localparam logic [POLL_W-1:0]    RST_POLL_PERIOD         = 10'd10;
    localparam logic                 RST_SWITCHES_ACTIVE_LOW = 1'b1;
    localparam logic [7:0]           SPEED_LIMIT             = 8'd100;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX             = {ELAPSED_W{1'b1}};

    typedef struct packed {
        logic       func;
        logic [1:0] target;
        logic       up_raw;
        logic       down_raw;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] up_drive_level;
        logic [LEVEL_W-1:0] down_drive_level;
        logic               busy_res;
        logic               finished;
        logic               reached;
    } out_word_t;

    typedef struct packed {
        logic [7:0]        drive_pct;
        logic [15:0]       stop_limit;
        logic [POLL_W-1:0] poll_period;
        logic              switches_active_low;
    } cfg_t;

    // min(pct, 100) * 10, done as two shifts and an add
    function automatic logic [LEVEL_W-1:0] level_of_speed(input logic [7:0] pct);
        logic [6:0]         c;
        logic [LEVEL_W-1:0] lvl;
        c   = (pct > SPEED_LIMIT) ? SPEED_LIMIT[6:0] : pct[6:0];
        lvl = {c, 3'b000} + {2'b00, c, 1'b0};
        return lvl;
    endfunction

endpackage

// File: hdl/endstop_motor_positioner_top.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data   (in_word_t)
// out     | output    | out_valid / out_ready | out_data  (out_word_t)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one result word per input word, registered into the output register on acceptance
// a new word is taken every cycle while the output register is empty or being drained
// the whole step is one pass of next-state logic from input port to output register
// reset (rst_n, async low) idles the motor and loads register defaults
// a stalled output holds its word and blocks input only while it is full
module endstop_motor_positioner_top
    import emp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;
    out_word_t result;
    logic      step;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    emp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_pct           <= RST_DRIVE_PCT;
            cfg_reg.stop_limit          <= RST_STOP_LIMIT;
            cfg_reg.poll_period         <= RST_POLL_PERIOD;
            cfg_reg.switches_active_low <= RST_SWITCHES_ACTIVE_LOW;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DRIVE_PCT:           cfg_reg.drive_pct           <= cfg_data[7:0];
                CFG_STOP_LIMIT:          cfg_reg.stop_limit          <= cfg_data[15:0];
                CFG_POLL_PERIOD:         cfg_reg.poll_period         <= cfg_data[POLL_W-1:0];
                CFG_SWITCHES_ACTIVE_LOW: cfg_reg.switches_active_low <= cfg_data[0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= result;
    end

endmodule

// File: hdl/emp_core.sv
module emp_core
    import emp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  word,
    input  cfg_t      cfg,
    output out_word_t result
);

    mode_t                mode_reg, mode_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [POLL_W-1:0]    countdown_reg, countdown_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;

    logic                 up_p, down_p, cmd_valid_target, cmd_pressed, mov_pressed;
    logic [POLL_W-1:0]    reload, cd_dec;
    logic [ELAPSED_W-1:0] el_inc;
    logic                 poll_now, timed_out;
    logic                 fin, ok;

    assign up_p   = word.up_raw ^ cfg.switches_active_low;
    assign down_p = word.down_raw ^ cfg.switches_active_low;
    assign reload = (cfg.poll_period == '0) ? POLL_W'(1) : cfg.poll_period;

    assign cmd_valid_target = (word.target == TARGET_UP) || (word.target == TARGET_DOWN);
    assign cmd_pressed      = (word.target == TARGET_UP) ? up_p : down_p;
    assign mov_pressed      = (mode_reg == MODE_UP) ? up_p : down_p;

    assign el_inc    = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + ELAPSED_W'(1) : elapsed_reg;
    assign cd_dec    = (countdown_reg != '0) ? countdown_reg - POLL_W'(1) : countdown_reg;
    assign poll_now  = (cd_dec == '0);
    assign timed_out = el_inc > {1'b0, cfg.stop_limit};

    // completion flags
    always_comb
    begin
        fin = 1'b0;
        ok  = 1'b0;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (word.func == FUNC_COMMAND)
                begin
                    fin = !cmd_valid_target || cmd_pressed;
                    ok  = cmd_valid_target && cmd_pressed;
                end
            end
            MODE_UP, MODE_DOWN:
            begin
                if (word.func == FUNC_TICK && poll_now)
                begin
                    fin = timed_out || mov_pressed;
                    ok  = !timed_out && mov_pressed;
                end
            end
            default:
            begin
                fin = 1'b0;
                ok  = 1'b0;
            end
        endcase
    end

    // next move mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (word.func == FUNC_COMMAND && !fin)
                    mode_next = (word.target == TARGET_UP) ? MODE_UP : MODE_DOWN;
            end
            MODE_UP, MODE_DOWN:
            begin
                if (fin)
                    mode_next = MODE_IDLE;
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // counters, latched level and result word
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        countdown_next = countdown_reg;
        level_next     = level_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (word.func == FUNC_COMMAND && !fin)
                begin
                    elapsed_next   = '0;
                    countdown_next = reload;
                    level_next     = level_of_speed(cfg.drive_pct);
                end
            end
            MODE_UP, MODE_DOWN:
            begin
                if (word.func == FUNC_TICK)
                begin
                    if (fin)
                    begin
                        elapsed_next   = '0;
                        countdown_next = '0;
                        level_next     = '0;
                    end
                    else
                    begin
                        elapsed_next   = el_inc;
                        countdown_next = poll_now ? reload : cd_dec;
                    end
                end
            end
            default:
            begin
                elapsed_next   = '0;
                countdown_next = '0;
                level_next     = '0;
            end
        endcase

        result.up_drive_level   = (mode_next == MODE_UP) ? level_next : '0;
        result.down_drive_level = (mode_next == MODE_DOWN) ? level_next : '0;
        result.busy_res         = (mode_next != MODE_IDLE);
        result.finished         = fin;
        result.reached          = ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            elapsed_reg   <= '0;
            countdown_reg <= '0;
            level_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            elapsed_reg   <= elapsed_next;
            countdown_reg <= countdown_next;
            level_reg     <= level_next;
        end
    end

endmodule

// File: hdl/emp_checker.sv
module emp_checker
    import emp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // success is only reported on a finishing word
    a_reached_needs_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reached |-> out_data.finished)
        else $error("reached without finished");

    // a finishing word always leaves the motor stopped
    a_finished_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.finished |->
            !out_data.busy_res && out_data.up_drive_level == '0 &&
            out_data.down_drive_level == '0)
        else $error("finished word still drives the motor");

    // never drive both bridge inputs, and drive only while busy
    a_single_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.up_drive_level != '0 || out_data.down_drive_level != '0) |->
            out_data.busy_res &&
            (out_data.up_drive_level == '0 || out_data.down_drive_level == '0))
        else $error("drive level outside a single-direction move");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output word changed");

endmodule

bind endstop_motor_positioner_top emp_checker u_emp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
